// ===== hdl/vbre_pkg.sv =====
// Shared types and constants for the VLAN bitmap range encoder.
// Used by every module of the block and by its checker; depends on nothing.
package vbre_pkg;

  localparam int unsigned VidW        = 12;
  localparam int unsigned VidCountDef = 4096;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned CmdSlots    = 3;
  localparam int unsigned CmdDepth    = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode         = 2'd0,
    CfgPvidEnable   = 2'd1,
    CfgPvidValue    = 2'd2,
    CfgPvidUntagged = 2'd3
  } cfg_idx_e;

  localparam logic ModeSet    = 1'b0;
  localparam logic ModeDelete = 1'b1;

  typedef struct packed {
    logic [VidW-1:0] vlan_id;
    logic            want_member;
    logic            want_untagged;
    logic            now_member;
    logic            scan_end;
  } item_t;

  typedef struct packed {
    logic [VidW-1:0] entry_vid;
    logic            entry_untagged;
    logic            entry_pvid;
    logic            range_first;
    logic            range_final;
    logic            last_of_run;
  } result_t;

  // All entries caused by one item; cnt is 1 to CmdSlots.
  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [CmdSlots-1:0]     ent;
  } cmd_t;

endpackage

// ===== hdl/vbre_front.sv =====
// Front end: configuration registers, run tracking and entry generation.
// Each accepted item becomes one command of up to three entries. Uses vbre_pkg.
module vbre_front #(
  parameter int unsigned VID_COUNT = vbre_pkg::VidCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vbre_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vbre_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          accept_i,
  input  vbre_pkg::item_t               item_i,
  output logic                          cmd_push_o,
  output vbre_pkg::cmd_t                cmd_o
);
  import vbre_pkg::*;

  localparam logic [VidW-1:0] LastVid = VidW'(VID_COUNT - 1);
  localparam int unsigned     NumCand = 5;

  logic            mode_q, pvid_en_q, pvid_untag_q;
  logic [VidW-1:0] pvid_val_q;
  logic            run_open_q, run_open_d;
  logic [VidW-1:0] run_start_q, run_start_d;
  logic            run_tag_q, run_tag_d;

  logic [VidW-1:0] k, prev;
  logic            is_pvid, close_a, pvid_hit, open1, tag1, flush_b, last_id;
  logic [VidW-1:0] start1;
  result_t         cand [NumCand];
  logic [NumCand-1:0] cand_vld;
  logic [1:0]      n;
  cmd_t            cmd;

  always_comb begin
    k        = item_i.vlan_id;
    prev     = k - VidW'(1);
    is_pvid  = pvid_en_q && (k == pvid_val_q);
    close_a  = 1'b0;
    pvid_hit = 1'b0;
    open1    = run_open_q;
    start1   = run_start_q;
    tag1     = run_tag_q;

    if (mode_q == ModeSet) begin
      if (is_pvid) begin
        close_a  = run_open_q;
        open1    = 1'b0;
        pvid_hit = 1'b1;
      end else if (!item_i.want_member) begin
        close_a = run_open_q;
        open1   = 1'b0;
      end else if (run_open_q) begin
        // A change of untagged flag ends the run and starts a fresh one here.
        if (run_tag_q != item_i.want_untagged) begin
          close_a = 1'b1;
          start1  = k;
          tag1    = item_i.want_untagged;
        end
      end else begin
        open1  = 1'b1;
        start1 = k;
        tag1   = item_i.want_untagged;
      end
    end else begin
      if (is_pvid || !item_i.now_member || item_i.want_member) begin
        close_a = run_open_q;
        open1   = 1'b0;
      end else if (!run_open_q) begin
        open1  = 1'b1;
        start1 = k;
        tag1   = 1'b0;
      end
    end

    last_id = item_i.scan_end || (k == LastVid);
    flush_b = last_id && open1;

    // Candidate entries in output order; unused ones are squeezed out below.
    cand[0] = '{entry_vid: run_start_q, entry_untagged: run_tag_q, entry_pvid: 1'b0,
                range_first: (prev != run_start_q), range_final: 1'b0, last_of_run: 1'b0};
    cand[1] = '{entry_vid: prev, entry_untagged: run_tag_q, entry_pvid: 1'b0,
                range_first: 1'b0, range_final: 1'b1, last_of_run: 1'b0};
    cand[2] = '{entry_vid: k, entry_untagged: pvid_untag_q, entry_pvid: 1'b1,
                range_first: 1'b0, range_final: 1'b0, last_of_run: 1'b0};
    cand[3] = '{entry_vid: start1, entry_untagged: tag1, entry_pvid: 1'b0,
                range_first: (k != start1), range_final: 1'b0, last_of_run: 1'b0};
    cand[4] = '{entry_vid: k, entry_untagged: tag1, entry_pvid: 1'b0,
                range_first: 1'b0, range_final: 1'b1, last_of_run: 1'b0};
    cand_vld = {flush_b && (k != start1), flush_b, pvid_hit,
                close_a && (prev != run_start_q), close_a};

    cmd = '0;
    n   = 2'd0;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_vld[i] && (n != 2'd3)) begin
        cmd.ent[n] = cand[i];
        n          = n + 2'd1;
      end
    end
    cmd.cnt = n;
    for (int j = 0; j < CmdSlots; j++) begin
      cmd.ent[j].last_of_run = (2'(j) == n - 2'd1);
    end

    run_open_d  = open1 && !last_id;
    run_start_d = start1;
    run_tag_d   = tag1;
  end

  assign cmd_push_o = accept_i && (n != 2'd0);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeSet;
      pvid_en_q    <= 1'b0;
      pvid_val_q   <= '0;
      pvid_untag_q <= 1'b0;
      run_open_q   <= 1'b0;
      run_start_q  <= '0;
      run_tag_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgMode:         mode_q       <= cfg_data_i[0];
          CfgPvidEnable:   pvid_en_q    <= cfg_data_i[0];
          CfgPvidValue:    pvid_val_q   <= cfg_data_i[VidW-1:0];
          CfgPvidUntagged: pvid_untag_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept_i) begin
        run_open_q  <= run_open_d;
        run_start_q <= run_start_d;
        run_tag_q   <= run_tag_d;
      end
    end
  end

endmodule

// ===== hdl/vbre_cmd_fifo.sv =====
// Short command queue between the front end and the entry serialiser.
// Holds whole commands; uses cmd_t from vbre_pkg.
module vbre_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vbre_pkg::cmd_t data_i,
  input  logic           pop_i,
  output vbre_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import vbre_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/vbre_back.sv =====
// Back end: walks the entries of the oldest command, one transfer per cycle
// while pop_i is high. Uses cmd_t and result_t from vbre_pkg.
module vbre_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vbre_pkg::cmd_t    head_i,
  input  logic              head_empty_i,
  output logic              head_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output vbre_pkg::result_t result_o
);
  import vbre_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       xfer, last_ent;

  assign empty_o    = head_empty_i;
  assign result_o   = head_i.ent[idx_q];
  assign xfer       = pop_i && !head_empty_i;
  assign last_ent   = (idx_q == head_i.cnt - 2'd1);
  assign head_pop_o = xfer && last_ent;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = last_ent ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hdl/vlan_bitmap_range_encoder_top.sv =====
// Top level of the VLAN bitmap range encoder.
// Instantiates vbre_front, vbre_cmd_fifo and vbre_back; uses vbre_pkg.
//
// Usage:
//   Input channel: one VLAN ID position per transfer (push_i, full_o), IDs in
//   ascending order, scan_end set on the last one. Output channel: range
//   entries (empty_o, pop_i), oldest first. The configuration port writes
//   mode, PVID enable, PVID value and PVID untagged flag; write it only while
//   no items are in flight.
//   An item is classified in the cycle it is transferred in, and its entries
//   (none, one, two or three) join the queue and appear on result_o in order.
//   Items are taken one per cycle while full_o is low. Each entry leaves in a
//   cycle of its own, so sustained input rate is one item per cycle as long
//   as, on average, no more than one entry per item is produced; bursts of
//   multi-entry items are taken up by a four-command queue, then full_o rises.
//   A stalled receiver only holds the current entry; the front keeps taking
//   items until the queue fills.
//   Reset clears the configuration to set mode with no PVID, closes any open
//   run and empties the queue.
module vlan_bitmap_range_encoder_top #(
  parameter int unsigned VID_COUNT = vbre_pkg::VidCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vbre_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vbre_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  vbre_pkg::item_t               item_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output vbre_pkg::result_t             result_o
);
  import vbre_pkg::*;

  logic accept, cmd_push, head_pop, head_empty;
  cmd_t cmd, head;

  assign accept = push_i && !full_o;

  vbre_front #(
    .VID_COUNT (VID_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  vbre_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd),
    .pop_i   (head_pop),
    .head_o  (head),
    .full_o  (full_o),
    .empty_o (head_empty)
  );

  vbre_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .result_o     (result_o)
  );

endmodule

// ===== hdl/vbre_checker.sv =====
// Port-level checks for the VLAN bitmap range encoder, bound to the top level.
// Uses vbre_pkg for the payload types.
module vbre_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_o,
  input  logic              empty_o,
  input  logic              pop_i,
  input  vbre_pkg::result_t result_o
);
  import vbre_pkg::*;

  // A waiting entry stays put until it is transferred.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(result_o))
    else $error("result changed while stalled");

  // Nothing appears at the output without an input transfer.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o && !(push_i && !full_o) |=> empty_o)
    else $error("result appeared without an input transfer");

  // A begin entry is never the last entry of its item.
  a_begin_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && result_o.range_first |-> !result_o.last_of_run)
    else $error("range begin marked as last entry");

  // The PVID entry is never flagged as a range begin or end.
  a_pvid_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && result_o.entry_pvid |-> !result_o.range_first && !result_o.range_final)
    else $error("PVID entry flagged as part of a range");

  // The queue cannot be full and empty at once.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o)
    else $error("full and empty together");

endmodule

bind vlan_bitmap_range_encoder_top vbre_checker u_vbre_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push_i   (push_i),
  .full_o   (full_o),
  .empty_o  (empty_o),
  .pop_i    (pop_i),
  .result_o (result_o)
);

// ===== test/vlan_bitmap_range_encoder_top_tb.sv =====
// Self-checking testbench for vlan_bitmap_range_encoder_top.
// It runs a directed table and then random VLAN scans, checking range entries against
// the predictor or typed table entries. It depends on vbre_pkg and the top level only.
module vlan_bitmap_range_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vbre_pkg::*;

  localparam logic [VidW-1:0] LastVid     = VidW'(VidCountDef - 1);
  localparam int unsigned     CycleLimit  = 200000;
  localparam int unsigned     DrainCycles = 8;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CfgDataW-1:0]   data;
    item_t                 it;
    int                    n_typed;   // -1: expectation comes from the predictor
    result_t [2:0]         typed;
  } row_t;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  cfg_idx_e            cfg_idx  = CfgMode;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                push     = 1'b0;
  logic                full;
  item_t               item     = '0;
  logic                empty;
  logic                pop      = 1'b0;
  result_t             result;

  // Predictor copy of the configuration and of the open run.
  logic           cfg_mode     = ModeSet;
  logic           cfg_pvid_en  = 1'b0;
  logic [VidW-1:0] cfg_pvid    = '0;
  logic           cfg_pvid_unt = 1'b0;
  logic           run_open     = 1'b0;
  logic [VidW-1:0] run_first   = '0;
  logic           run_unt      = 1'b0;

  result_t     new_entries[$];
  result_t     pending_entries[$];
  int unsigned mismatches    = 0;
  int unsigned positions     = 0;
  int unsigned entries_seen  = 0;
  int unsigned reg_writes    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned cycles        = 0;
  int unsigned tx_idle_pct   = 37;
  int unsigned rx_idle_pct   = 83;
  int unsigned hold_left     = 0;
  bit          hold_req      = 1'b0;
  bit          hold_taken    = 1'b0;

  vlan_bitmap_range_encoder_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push_i     (push),
    .full_o     (full),
    .item_i     (item),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void add_entry(input logic [VidW-1:0] vid, input logic unt,
                                    input logic pvid, input logic first, input logic fin);
    result_t e;
    e.entry_vid      = vid;
    e.entry_untagged = unt;
    e.entry_pvid     = pvid;
    e.range_first    = first;
    e.range_final    = fin;
    e.last_of_run    = 1'b0;
    new_entries.push_back(e);
  endfunction

  function automatic void close_run(input logic [VidW-1:0] end_vid);
    if (!run_open) return;
    if (end_vid == run_first) begin
      add_entry(run_first, run_unt, 1'b0, 1'b0, 1'b0);
    end else begin
      add_entry(run_first, run_unt, 1'b0, 1'b1, 1'b0);
      add_entry(end_vid, run_unt, 1'b0, 1'b0, 1'b1);
    end
    run_open = 1'b0;
  endfunction

  function automatic void open_run(input logic [VidW-1:0] vid, input logic unt);
    run_open  = 1'b1;
    run_first = vid;
    run_unt   = unt;
  endfunction

  // Works out the entries that one scan position causes, into new_entries.
  function automatic void encode_position(input item_t it);
    logic [VidW-1:0] prev;
    logic            is_pvid;
    new_entries.delete();
    prev    = it.vlan_id - 1'b1;
    is_pvid = cfg_pvid_en && (it.vlan_id == cfg_pvid);
    if (cfg_mode == ModeSet) begin
      if (is_pvid) begin
        close_run(prev);
        add_entry(it.vlan_id, cfg_pvid_unt, 1'b1, 1'b0, 1'b0);
      end else if (!it.want_member) begin
        close_run(prev);
      end else if (run_open) begin
        if (run_unt != it.want_untagged) begin
          close_run(prev);
          open_run(it.vlan_id, it.want_untagged);
        end
      end else begin
        open_run(it.vlan_id, it.want_untagged);
      end
    end else begin
      if (is_pvid || !it.now_member || it.want_member) close_run(prev);
      else if (!run_open) open_run(it.vlan_id, 1'b0);
    end
    // The last position of a scan flushes whatever is still open.
    if (it.scan_end || it.vlan_id == LastVid) close_run(it.vlan_id);
    if (new_entries.size() > 0) new_entries[new_entries.size()-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Table helpers
  // ---------------------------------------------------------------------------
  function automatic row_t itm(input int vid, input int want, input int unt,
                               input int now, input int fin);
    row_t r;
    r.kind             = RowItem;
    r.idx              = CfgMode;
    r.data             = '0;
    r.it.vlan_id       = VidW'(vid);
    r.it.want_member   = 1'(want);
    r.it.want_untagged = 1'(unt);
    r.it.now_member    = 1'(now);
    r.it.scan_end      = 1'(fin);
    r.n_typed          = -1;
    r.typed            = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(input cfg_idx_e idx, input int data);
    row_t r;
    r      = itm(0, 0, 0, 0, 0);
    r.kind = RowCfg;
    r.idx  = idx;
    r.data = CfgDataW'(data);
    return r;
  endfunction

  function automatic result_t ent(input int vid, input int unt, input int pvid,
                                  input int first, input int fin, input int last);
    result_t e;
    e.entry_vid      = VidW'(vid);
    e.entry_untagged = 1'(unt);
    e.entry_pvid     = 1'(pvid);
    e.range_first    = 1'(first);
    e.range_final    = 1'(fin);
    e.last_of_run    = 1'(last);
    return e;
  endfunction

  function automatic row_t with_ents(input row_t r, input int n, input result_t e0,
                                     input result_t e1, input result_t e2);
    r.n_typed  = n;
    r.typed[0] = e0;
    r.typed[1] = e1;
    r.typed[2] = e2;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it, input int n_typed, input result_t [2:0] typed);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_position(it);
    if (n_typed < 0) begin
      foreach (new_entries[k]) pending_entries.push_back(new_entries[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) pending_entries.push_back(typed[k]);
    end
    positions++;
  endtask

  // Stops offering items and waits until every expected entry has come out.
  task automatic settle();
    push <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CfgMode:         cfg_mode     = data[0];
      CfgPvidEnable:   cfg_pvid_en  = data[0];
      CfgPvidValue:    cfg_pvid     = data[VidW-1:0];
      CfgPvidUntagged: cfg_pvid_unt = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [VidW-1:0] got,
                                 input logic [VidW-1:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_entry(input result_t got);
    result_t want;
    if (pending_entries.size() == 0) begin
      report_mismatch("entry transfer with nothing pending, vid", got.entry_vid, '0);
      return;
    end
    want = pending_entries.pop_front();
    entries_seen++;
    if (got.entry_vid !== want.entry_vid)
      report_mismatch("entry_vid", got.entry_vid, want.entry_vid);
    if (got.entry_untagged !== want.entry_untagged)
      report_mismatch("entry_untagged", VidW'(got.entry_untagged),
                      VidW'(want.entry_untagged));
    if (got.entry_pvid !== want.entry_pvid)
      report_mismatch("entry_pvid", VidW'(got.entry_pvid), VidW'(want.entry_pvid));
    if (got.range_first !== want.range_first)
      report_mismatch("range_first", VidW'(got.range_first), VidW'(want.range_first));
    if (got.range_final !== want.range_final)
      report_mismatch("range_final", VidW'(got.range_final), VidW'(want.range_final));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", VidW'(got.last_of_run), VidW'(want.last_of_run));
  endtask

  // Receiver: takes entries, idles at random, and holds off for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) check_entry(result);
      if (hold_req && !hold_taken) begin
        hold_left  = 80;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (push && full) stall_cycles++;
    if (cycles >= CycleLimit) begin
      $display("vlan_bitmap_range_encoder_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t            rows[$];
    item_t           it;
    logic [VidW-1:0] next_vid;
    int unsigned     scan_left;
    bit              want, unt, now;

    rows.push_back(with_ents(itm(0, 0, 0, 0, 0), 0, '0, '0, '0));
    rows.push_back(itm(1, 1, 0, 0, 0));
    rows.push_back(itm(2, 1, 0, 0, 0));
    rows.push_back(itm(3, 1, 1, 0, 0));      // untagged flag changes: run 1..2 closes
    rows.push_back(itm(4, 0, 0, 0, 0));      // one-ID run
    rows.push_back(cfg_row(CfgPvidValue, 6));
    rows.push_back(cfg_row(CfgPvidUntagged, 1));
    rows.push_back(cfg_row(CfgPvidEnable, 1));
    rows.push_back(itm(5, 1, 0, 0, 0));
    rows.push_back(itm(6, 1, 1, 0, 0));      // PVID closes the run and stands alone
    rows.push_back(itm(7, 1, 0, 0, 0));
    rows.push_back(itm(8, 1, 0, 0, 0));
    rows.push_back(itm(9, 1, 1, 0, 1));      // range, new run and flush: three entries
    rows.push_back(cfg_row(CfgPvidValue, 4095));
    rows.push_back(itm(4093, 1, 1, 0, 0));
    rows.push_back(itm(4094, 1, 1, 0, 0));
    rows.push_back(with_ents(itm(4095, 1, 0, 0, 0), 3, ent(4093, 1, 0, 1, 0, 0),
                             ent(4094, 1, 0, 0, 1, 0), ent(4095, 1, 1, 0, 0, 1)));
    rows.push_back(cfg_row(CfgPvidEnable, 0));
    rows.push_back(itm(4094, 1, 0, 0, 0));   // repeated ID, going backwards
    rows.push_back(with_ents(itm(4095, 1, 0, 0, 0), 2, ent(4094, 0, 0, 1, 0, 0),
                             ent(4095, 0, 0, 0, 1, 1), '0));
    rows.push_back(cfg_row(CfgMode, int'(ModeDelete)));
    rows.push_back(itm(0, 0, 0, 1, 0));
    rows.push_back(itm(1, 0, 1, 1, 0));
    rows.push_back(itm(2, 1, 0, 1, 0));      // still wanted, so not deleted
    rows.push_back(itm(3, 0, 0, 0, 0));
    rows.push_back(itm(5, 0, 0, 1, 0));
    rows.push_back(cfg_row(CfgMode, int'(ModeSet)));
    // Mode change with a run open, closed by an ID below its start: end wraps to 4095.
    rows.push_back(with_ents(itm(0, 0, 0, 0, 0), 2, ent(5, 0, 0, 1, 0, 0),
                             ent(4095, 0, 0, 0, 1, 1), '0));
    rows.push_back(cfg_row(CfgMode, int'(ModeDelete)));
    rows.push_back(cfg_row(CfgPvidValue, 20));
    rows.push_back(cfg_row(CfgPvidEnable, 1));
    rows.push_back(itm(19, 0, 0, 1, 0));
    rows.push_back(itm(20, 0, 0, 1, 0));     // the PVID is never deleted
    rows.push_back(itm(21, 0, 0, 1, 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg) begin
        settle();
        write_cfg(rows[i].idx, rows[i].data);
      end else begin
        send_item(rows[i].it, rows[i].n_typed, rows[i].typed);
      end
    end

    // Random scans: six register settings, two per idling pattern.
    next_vid  = '0;
    scan_left = 0;
    want      = 1'b0;
    unt       = 1'b0;
    now       = 1'b0;
    for (int s = 0; s < 6; s++) begin
      settle();
      case (s / 2)
        0: begin tx_idle_pct = 37; rx_idle_pct = 83; end
        1: begin tx_idle_pct = 83; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_cfg(CfgMode, CfgDataW'((s % 2 == 0) ? ModeSet : ModeDelete));
      write_cfg(CfgPvidEnable, CfgDataW'((s == 2 || s == 5) ? 1'b0 : 1'b1));
      case (s)
        1, 4:    write_cfg(CfgPvidValue, '0);
        2, 3:    write_cfg(CfgPvidValue, LastVid);
        default: write_cfg(CfgPvidValue, CfgDataW'($urandom_range(4095)));
      endcase
      write_cfg(CfgPvidUntagged, CfgDataW'($urandom_range(1)));
      // With nothing idling, the receiver backs off so the command queue fills.
      if (s == 4) hold_req = 1'b1;
      for (int n = 0; n < 21; n++) begin
        if (scan_left == 0) begin
          scan_left = $urandom_range(3, 16);
          case ($urandom_range(2))
            0:       next_vid = cfg_pvid - VidW'($urandom_range(0, 6));
            1:       next_vid = LastVid - VidW'($urandom_range(0, 20));
            default: next_vid = VidW'($urandom_range(4095));
          endcase
        end
        if ($urandom_range(99) < 30) want = !want;
        if ($urandom_range(99) < 20) unt  = !unt;
        if ($urandom_range(99) < 30) now  = !now;
        scan_left--;
        it.vlan_id       = ($urandom_range(99) < 5) ? VidW'($urandom_range(4095)) : next_vid;
        it.want_member   = want;
        it.want_untagged = unt;
        it.now_member    = now;
        it.scan_end      = (scan_left == 0) || ($urandom_range(99) < 2);
        if (it.vlan_id == LastVid || it.scan_end) scan_left = 0;
        next_vid = it.vlan_id + 1'b1;
        send_item(it, -1, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d scan positions over %0d register writes; checked %0d range entries.",
             positions, reg_writes, entries_seen);
    $display("Input was held back by a full queue on %0d cycles.", stall_cycles);
    if (mismatches == 0) begin
      $display("vlan_bitmap_range_encoder_top: match");
    end else begin
      $display("vlan_bitmap_range_encoder_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vbre_pkg.sv
hdl/vbre_front.sv
hdl/vbre_cmd_fifo.sv
hdl/vbre_back.sv
hdl/vlan_bitmap_range_encoder_top.sv
hdl/vbre_checker.sv
test/vlan_bitmap_range_encoder_top_tb.sv
